// ===== hw/rtl/risq_pkg.sv =====
// shared types, command codes and status flags for the radio irq service sequencer
package risq_pkg;

  localparam logic [1:0] TX_SLOTS    = 2'd3;
  localparam logic [5:0] MAX_PAYLOAD = 6'd32;

  localparam logic [7:0] CMD_NOP              = 8'hFF;
  localparam logic [7:0] CMD_WRITE_STATUS     = 8'h27;
  localparam logic [7:0] CMD_READ_WIDTH       = 8'h60;
  localparam logic [7:0] CMD_READ_PAYLOAD     = 8'h61;
  localparam logic [7:0] CMD_READ_FIFO_STATUS = 8'h17;

  localparam logic [7:0] FLAG_TX_DONE  = 8'h20;
  localparam logic [7:0] FLAG_TX_FAIL  = 8'h10;
  localparam logic [7:0] FLAG_RX_READY = 8'h40;
  localparam logic [7:0] FLAG_RX_EMPTY = 8'h01;

  localparam logic [2:0] REG_IS_RECEIVER = 3'd0;

  typedef enum logic [1:0] {
    OP_IRQ    = 2'd0,
    OP_BYTE   = 2'd1,
    OP_LOADED = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CE_KEEP = 2'd0,
    CE_LOW  = 2'd1,
    CE_HIGH = 2'd2,
    CE_RSVD = 2'd3
  } ce_t;

  typedef enum logic [3:0] {
    S_IDLE        = 4'd0,
    S_STATUS      = 4'd1,
    S_WIDTH_CMD   = 4'd2,
    S_WIDTH_READ  = 4'd3,
    S_PAYLOAD_CMD = 4'd4,
    S_FIRST       = 4'd5,
    S_BODY        = 4'd6,
    S_CLEAR       = 4'd7,
    S_FIFO_CMD    = 4'd8,
    S_FIFO_NOP    = 4'd9,
    S_FIFO_READ   = 4'd10
  } seq_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       start_transfer;
    logic       select_release;
    logic       select_level;
    logic [1:0] ce_action;
    logic       irq_enabled;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       tx_fail_event;
    logic [1:0] credits;
    logic       busy_res;
    logic       accepted;
  } rsp_t;

  typedef struct packed {
    seq_t       seq_state;
    logic [1:0] fifo_credits;
    logic       service_busy;
    logic [5:0] bytes_left;
    logic [7:0] clear_mask;
  } seq_ctx_t;

endpackage

// ===== hw/rtl/risq_step.sv =====
// next-state and result logic for one input word
module risq_step (
  input  risq_pkg::seq_ctx_t ctx,
  input  risq_pkg::req_t     req,
  input  logic               is_receiver,
  output risq_pkg::seq_ctx_t ctx_next,
  output risq_pkg::rsp_t     res
);

  logic [7:0] width_sat;

  always_comb begin
    if ({2'b00, ctx.bytes_left} > 8'd0 && req.rx_byte > {2'b00, risq_pkg::MAX_PAYLOAD}) begin
      width_sat = {2'b00, risq_pkg::MAX_PAYLOAD};
    end else if (req.rx_byte > {2'b00, risq_pkg::MAX_PAYLOAD}) begin
      width_sat = {2'b00, risq_pkg::MAX_PAYLOAD};
    end else begin
      width_sat = req.rx_byte;
    end
  end

  always_comb begin
    ctx_next = ctx;
    res      = '0;

    case (risq_pkg::op_t'(req.op))
      risq_pkg::OP_IRQ: begin
        if (!ctx.service_busy) begin
          ctx_next.service_busy = 1'b1;
          ctx_next.seq_state    = risq_pkg::S_STATUS;
          res.tx_byte           = risq_pkg::CMD_NOP;
          res.start_transfer    = 1'b1;
        end
      end
      risq_pkg::OP_BYTE: begin
        case (ctx.seq_state)
          risq_pkg::S_IDLE: begin
          end
          risq_pkg::S_STATUS: begin
            if ((req.rx_byte & risq_pkg::FLAG_TX_DONE) != 8'd0) begin
              if (ctx.fifo_credits < risq_pkg::TX_SLOTS) begin
                ctx_next.fifo_credits = ctx.fifo_credits + 2'd1;
              end
              if (!is_receiver) begin
                res.ce_action = risq_pkg::CE_LOW;
              end
              ctx_next.clear_mask = risq_pkg::FLAG_TX_DONE;
              ctx_next.seq_state  = risq_pkg::S_CLEAR;
              res.tx_byte         = risq_pkg::CMD_WRITE_STATUS;
              res.start_transfer  = 1'b1;
              res.select_release  = 1'b1;
            end else if ((req.rx_byte & risq_pkg::FLAG_TX_FAIL) != 8'd0) begin
              if (!is_receiver) begin
                res.ce_action = risq_pkg::CE_LOW;
              end
              res.tx_fail_event   = 1'b1;
              ctx_next.clear_mask = risq_pkg::FLAG_TX_FAIL;
              ctx_next.seq_state  = risq_pkg::S_CLEAR;
              res.tx_byte         = risq_pkg::CMD_WRITE_STATUS;
              res.start_transfer  = 1'b1;
              res.select_release  = 1'b1;
            end else if ((req.rx_byte & risq_pkg::FLAG_RX_READY) != 8'd0) begin
              ctx_next.seq_state = risq_pkg::S_WIDTH_CMD;
              res.tx_byte        = risq_pkg::CMD_READ_WIDTH;
              res.start_transfer = 1'b1;
              res.select_release = 1'b1;
            end else begin
              // no source left: end the service sequence
              ctx_next.service_busy = 1'b0;
              ctx_next.seq_state    = risq_pkg::S_IDLE;
              res.select_release    = 1'b1;
              if (!is_receiver) begin
                res.ce_action = (ctx.fifo_credits < risq_pkg::TX_SLOTS) ?
                                risq_pkg::CE_HIGH : risq_pkg::CE_LOW;
              end
            end
          end
          risq_pkg::S_WIDTH_CMD: begin
            ctx_next.seq_state = risq_pkg::S_WIDTH_READ;
            res.tx_byte        = risq_pkg::CMD_NOP;
            res.start_transfer = 1'b1;
          end
          risq_pkg::S_WIDTH_READ: begin
            ctx_next.bytes_left = width_sat[5:0];
            ctx_next.seq_state  = risq_pkg::S_PAYLOAD_CMD;
            res.tx_byte         = risq_pkg::CMD_READ_PAYLOAD;
            res.start_transfer  = 1'b1;
            res.select_release  = 1'b1;
          end
          risq_pkg::S_PAYLOAD_CMD: begin
            ctx_next.seq_state = risq_pkg::S_FIRST;
            res.tx_byte        = risq_pkg::CMD_NOP;
            res.start_transfer = 1'b1;
          end
          risq_pkg::S_FIRST, risq_pkg::S_BODY: begin
            // a zero first byte is dropped but still counts against the width
            if (ctx.seq_state == risq_pkg::S_BODY || req.rx_byte != 8'd0) begin
              res.payload_byte  = req.rx_byte;
              res.payload_valid = 1'b1;
            end
            ctx_next.seq_state = risq_pkg::S_BODY;
            if (ctx.bytes_left <= 6'd1) begin
              ctx_next.bytes_left = 6'd0;
              ctx_next.clear_mask = risq_pkg::FLAG_RX_READY;
              ctx_next.seq_state  = risq_pkg::S_CLEAR;
              res.tx_byte         = risq_pkg::CMD_WRITE_STATUS;
              res.start_transfer  = 1'b1;
              res.select_release  = 1'b1;
            end else begin
              ctx_next.bytes_left = ctx.bytes_left - 6'd1;
              res.tx_byte         = risq_pkg::CMD_NOP;
              res.start_transfer  = 1'b1;
            end
          end
          risq_pkg::S_CLEAR: begin
            ctx_next.seq_state = risq_pkg::S_FIFO_CMD;
            res.tx_byte        = ctx.clear_mask;
            res.start_transfer = 1'b1;
          end
          risq_pkg::S_FIFO_CMD: begin
            ctx_next.seq_state = risq_pkg::S_FIFO_NOP;
            res.tx_byte        = risq_pkg::CMD_READ_FIFO_STATUS;
            res.start_transfer = 1'b1;
            res.select_release = 1'b1;
          end
          risq_pkg::S_FIFO_NOP: begin
            ctx_next.seq_state = risq_pkg::S_FIFO_READ;
            res.tx_byte        = risq_pkg::CMD_NOP;
            res.start_transfer = 1'b1;
          end
          risq_pkg::S_FIFO_READ: begin
            res.start_transfer = 1'b1;
            res.select_release = 1'b1;
            if ((req.rx_byte & risq_pkg::FLAG_RX_EMPTY) != 8'd0) begin
              ctx_next.seq_state = risq_pkg::S_STATUS;
              res.tx_byte        = risq_pkg::CMD_NOP;
            end else begin
              ctx_next.seq_state = risq_pkg::S_WIDTH_CMD;
              res.tx_byte        = risq_pkg::CMD_READ_WIDTH;
            end
          end
          default: begin
            ctx_next.seq_state    = risq_pkg::S_IDLE;
            ctx_next.service_busy = 1'b0;
          end
        endcase
      end
      risq_pkg::OP_LOADED: begin
        if (ctx.fifo_credits != 2'd0) begin
          ctx_next.fifo_credits = ctx.fifo_credits - 2'd1;
          res.accepted          = 1'b1;
          if (!is_receiver && (ctx.fifo_credits - 2'd1) < risq_pkg::TX_SLOTS) begin
            res.ce_action = risq_pkg::CE_HIGH;
          end
        end
      end
      default: begin
      end
    endcase

    res.select_level = ctx_next.service_busy;
    res.irq_enabled  = !ctx_next.service_busy;
    res.credits      = ctx_next.fifo_credits;
    res.busy_res     = ctx_next.service_busy;
  end

endmodule

// ===== hw/rtl/risq_skid.sv =====
// two-entry result buffer between the step logic and the result channel
module risq_skid (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  risq_pkg::rsp_t push_data,
  output logic           space,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output risq_pkg::rsp_t rsp
);

  risq_pkg::rsp_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           pop;

  assign pop       = rsp_valid && rsp_ready;
  assign space     = (count != 2'd2);
  assign rsp_valid = (count != 2'd0);
  assign rsp       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/radio_irq_service_sequencer_unit.sv =====
// top level: config register, sequencer state and result buffer
//
// channel | direction | handshake                 | word
// req     | in        | req_valid / req_ready     | op, rx_byte
// rsp     | out       | rsp_valid / rsp_ready     | one result per request
// apb     | in        | psel/penable/pwrite/pready| is_receiver at address 0
//
// one request per cycle while req_ready is high; decoding is combinational and the
// result is registered in a two-entry buffer, shown after any older one is taken.
// req_ready drops only when both buffer entries hold results not yet taken.
// rst is synchronous: sequencer idle, three tx credits, is_receiver cleared.
module radio_irq_service_sequencer_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  risq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output risq_pkg::rsp_t rsp,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  risq_pkg::seq_ctx_t ctx;
  risq_pkg::seq_ctx_t ctx_next;
  risq_pkg::rsp_t     res;
  logic               is_receiver;
  logic               push;
  logic               space;

  assign pready    = 1'b1;
  assign req_ready = space;
  assign push      = req_valid && req_ready;

  always_comb begin
    if (paddr == risq_pkg::REG_IS_RECEIVER) begin
      prdata = {31'd0, is_receiver};
    end else begin
      prdata = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      is_receiver <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr == risq_pkg::REG_IS_RECEIVER) begin
      is_receiver <= pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.seq_state    <= risq_pkg::S_IDLE;
      ctx.fifo_credits <= risq_pkg::TX_SLOTS;
      ctx.service_busy <= 1'b0;
      ctx.bytes_left   <= 6'd0;
      ctx.clear_mask   <= 8'd0;
    end else if (push) begin
      ctx <= ctx_next;
    end
  end

  risq_step u_step (
    .ctx         (ctx),
    .req         (req),
    .is_receiver (is_receiver),
    .ctx_next    (ctx_next),
    .res         (res)
  );

  risq_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .space     (space),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // busy flag and sequencer state move together
  a_busy_state: assert property (@(posedge clk) disable iff (rst)
    ctx.service_busy == (ctx.seq_state != risq_pkg::S_IDLE))
    else $error("busy flag disagrees with sequencer state");

  // a load with no credit leaves the credit count alone
  a_no_credit: assert property (@(posedge clk) disable iff (rst)
    (push && req.op == risq_pkg::OP_LOADED && ctx.fifo_credits == 2'd0)
      |=> $stable(ctx.fifo_credits))
    else $error("credit count changed on a rejected load");

  a_select_irq: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.select_level == rsp.busy_res && rsp.irq_enabled == !rsp.busy_res))
    else $error("select or irq enable out of step with busy");

  a_quiet_byte: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.start_transfer) |-> rsp.tx_byte == 8'd0)
    else $error("tx byte set without a transfer");

endmodule
